FILE: hdl/assert_macros.svh
// Assertion macros for the RTL files; png_sc_resq.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication, held off during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/png_sc_pkg.sv
// Shared types and constants of the PNG stream carver.
package png_sc_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PAT_LEN = 8;

    localparam logic [PAT_LEN*BYTE_W-1:0] SIG_PATTERN  = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [PAT_LEN*BYTE_W-1:0] TAIL_PATTERN = 64'h4945_4E44_AE42_6082;

    localparam logic KIND_IMAGE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] image_count;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] end_offset;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic    img_vld;
        logic    sum_vld;
        t_result img;
        t_result sum;
    } t_scan_out;

endpackage

FILE: hdl/png_sc_if.sv
// Stream channel interfaces of the PNG stream carver.
interface png_sc_in_if;
    logic                            valid;
    logic                            ready;
    logic [png_sc_pkg::BYTE_W-1:0]   data_byte;
    logic                            last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface png_sc_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [png_sc_pkg::FIELD_W-1:0]  image_count;
    logic [png_sc_pkg::FIELD_W-1:0]  start_offset;
    logic [png_sc_pkg::FIELD_W-1:0]  end_offset;
    logic                            last_result;

    modport source (output valid, output kind, output image_count, output start_offset,
                    output end_offset, output last_result, input ready);
    modport sink   (input valid, input kind, input image_count, input start_offset,
                    input end_offset, input last_result, output ready);
endinterface

FILE: hdl/png_sc_scan.sv
// Window matcher and image tracking state of the PNG stream carver.
module png_sc_scan #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_acc,
    input  logic [png_sc_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                  i_last_byte,
    output png_sc_pkg::t_scan_out                 o_scan
);
    import png_sc_pkg::*;

    localparam int unsigned WIN_W = (PAT_LEN - 1) * BYTE_W;
    localparam int unsigned EXT_W = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
    localparam logic [2:0]  FILL_FULL = 3'(PAT_LEN - 1);
    localparam logic [OFFSET_BITS-1:0] SIG_BACK = OFFSET_BITS'(PAT_LEN - 1);

    logic [WIN_W-1:0]       r_window;
    logic [2:0]             r_fill;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_start;
    logic                   r_inside;
    logic [FIELD_W-1:0]     r_count;

    logic [PAT_LEN*BYTE_W-1:0] w_full;
    logic                      w_sig_hit;
    logic                      w_tail_hit;
    logic [FIELD_W-1:0]        w_count_inc;
    logic [OFFSET_BITS-1:0]    w_end;
    logic [EXT_W-1:0]          w_start_ext;
    logic [EXT_W-1:0]          w_end_ext;

    assign w_full      = {r_window, i_data_byte};
    assign w_sig_hit   = (r_fill == FILL_FULL) && !r_inside && (w_full == SIG_PATTERN);
    assign w_tail_hit  = (r_fill == FILL_FULL) && r_inside && (w_full == TAIL_PATTERN);
    assign w_count_inc = (r_count != '1) ? r_count + FIELD_W'(1) : r_count;
    assign w_end       = (r_pos != '1) ? r_pos + OFFSET_BITS'(1) : r_pos;
    assign w_start_ext = EXT_W'(r_start);
    assign w_end_ext   = EXT_W'(w_end);

    always_comb begin
        o_scan.img_vld          = i_acc && w_tail_hit;
        o_scan.sum_vld          = i_acc && i_last_byte;
        o_scan.img.kind         = KIND_IMAGE;
        o_scan.img.image_count  = w_count_inc;
        o_scan.img.start_offset = w_start_ext[FIELD_W-1:0];
        o_scan.img.end_offset   = w_end_ext[FIELD_W-1:0];
        o_scan.img.last_result  = !i_last_byte;
        o_scan.sum.kind         = KIND_SUMMARY;
        o_scan.sum.image_count  = w_tail_hit ? w_count_inc : r_count;
        o_scan.sum.start_offset = '0;
        o_scan.sum.end_offset   = '0;
        o_scan.sum.last_result  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_last_byte)) begin
            r_window <= '0;
            r_fill   <= '0;
            r_pos    <= '0;
            r_start  <= '0;
            r_inside <= 1'b0;
            r_count  <= '0;
        end else if (i_acc) begin
            r_window <= w_full[WIN_W-1:0];
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + 3'd1;
            end
            if (r_pos != '1) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
            if (w_sig_hit) begin
                r_inside <= 1'b1;
                r_start  <= r_pos - SIG_BACK;
            end
            if (w_tail_hit) begin
                r_inside <= 1'b0;
                r_count  <= w_count_inc;
            end
        end
    end

endmodule

FILE: hdl/png_sc_resq.sv
// Three-entry result queue between the matcher and the output channel.
`include "assert_macros.svh"
module png_sc_resq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  png_sc_pkg::t_scan_out  i_scan,
    output logic                   o_in_ready,
    png_sc_out_if.source           o_out
);
    import png_sc_pkg::*;

    localparam int unsigned QDEPTH = 3;

    t_result    r_q [QDEPTH];
    logic [1:0] r_head;
    logic [1:0] r_tail;
    logic [1:0] r_count;

    logic [1:0] w_push_cnt;
    logic       w_pop;
    t_result    w_first;
    t_result    w_head_res;

    function automatic logic [1:0] q_next(input logic [1:0] idx);
        return (idx == 2'(QDEPTH - 1)) ? 2'd0 : idx + 2'd1;
    endfunction

    assign w_push_cnt = 2'(i_scan.img_vld) + 2'(i_scan.sum_vld);
    assign w_first    = i_scan.img_vld ? i_scan.img : i_scan.sum;
    assign w_pop      = o_out.valid && o_out.ready;
    assign w_head_res = r_q[r_head];

    // Room for the worst case of two results from the next byte.
    assign o_in_ready = (r_count <= 2'd1);

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.kind         = w_head_res.kind;
    assign o_out.image_count  = w_head_res.image_count;
    assign o_out.start_offset = w_head_res.start_offset;
    assign o_out.end_offset   = w_head_res.end_offset;
    assign o_out.last_result  = w_head_res.last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_pop) begin
                r_head <= q_next(r_head);
            end
            if (w_push_cnt == 2'd1) begin
                r_tail <= q_next(r_tail);
            end else if (w_push_cnt == 2'd2) begin
                r_tail <= q_next(q_next(r_tail));
            end
            r_count <= r_count + w_push_cnt - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != 2'd0) begin
            r_q[r_tail] <= w_first;
        end
        if (w_push_cnt == 2'd2) begin
            r_q[q_next(r_tail)] <= i_scan.sum;
        end
    end

    `CHK_IMPL(a_push_room, i_clk, i_rst_n, w_push_cnt != 2'd0, r_count <= 2'd1)
    `CHK_IMPL(a_summary_last, i_clk, i_rst_n,
              o_out.valid && (o_out.kind == KIND_SUMMARY), o_out.last_result)
    `CHK_NEXT(a_pop_drains, i_clk, i_rst_n,
              w_pop && (w_push_cnt == 2'd0), r_count == $past(r_count) - 2'd1)

endmodule

FILE: hdl/png_stream_carver.sv
// Top level of the PNG stream carver.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+------------
//  i_in    | in  | data_byte[7:0], last_byte                            | valid/ready
//  o_out   | out | kind, image_count, start_offset, end_offset,         | valid/ready
//          |     | last_result                                          |
//
//  One byte is taken per clock while ready is high; its results are written into
//  the result queue in the cycle the byte is accepted; the queue's head drives o_out.
//  Input ready drops whenever two or more results wait in the queue: for one cycle
//  after a byte that yields an image and a summary, and longer while o_out stalls.
//  Reset is synchronous, active low, and clears all tracking state and the queue.
//  A stall on o_out fills the queue and then holds off i_in; no transaction is lost.
module png_stream_carver #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    png_sc_in_if.sink     i_in,
    png_sc_out_if.source  o_out
);
    import png_sc_pkg::*;

    logic      w_in_ready;
    logic      w_acc;
    t_scan_out w_scan;

    // Accept a transaction whenever the queue can absorb two results.
    assign i_in.ready = w_in_ready;
    assign w_acc      = i_in.valid && w_in_ready;

    // Match the eight-byte window and advance offset, image and count state.
    png_sc_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_scan      (w_scan)
    );

    // Hold results, image before summary, until the sink takes them.
    png_sc_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (w_scan),
        .o_in_ready (w_in_ready),
        .o_out      (o_out)
    );

endmodule

FILE: dv/png_stream_carver_tb.sv
// Self-checking testbench of the PNG stream carver: directed rows, then random byte streams.
module png_stream_carver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import png_sc_pkg::*;

    localparam logic [FIELD_W-1:0] POS_MAX     = '1;   // OFFSET_BITS = 32
    localparam logic [FIELD_W-1:0] COUNT_MAX   = '1;
    localparam int                 STALL_LIMIT = 1000; // cycles without a transaction
    localparam int                 HOLD_CYCLES = 200;  // long receiver hold-off
    localparam int                 DRAIN_WAIT  = 8;    // settle time after the last result
    localparam int                 PHASE_ITEMS = 420;

    localparam t_result NO_REC    = '0;
    localparam t_result SUM_NONE  = '{KIND_SUMMARY, 32'd0, 32'd0, 32'd0, 1'b1};
    localparam t_result SUM_ONE   = '{KIND_SUMMARY, 32'd1, 32'd0, 32'd0, 1'b1};
    localparam t_result IMG_FIRST = '{KIND_IMAGE,   32'd1, 32'd0, 32'd16, 1'b0};

    // One row of the directed table; typed_recs = 0 defers to the carving predictor.
    typedef struct {
        logic [7:0] octet;
        logic       eos;
        int         typed_recs;
        t_result    rec_a;
        t_result    rec_b;
    } t_carve_row;

    localparam int N_DIRECTED = 26;

    t_carve_row directed_rows [N_DIRECTED] = '{
        // IEND tail in a fresh stream: no image is open, so only the empty summary
        '{8'h49, 1'b0, 0, NO_REC, NO_REC},
        '{8'h45, 1'b0, 0, NO_REC, NO_REC},
        '{8'h4E, 1'b0, 0, NO_REC, NO_REC},
        '{8'h44, 1'b0, 0, NO_REC, NO_REC},
        '{8'hAE, 1'b0, 0, NO_REC, NO_REC},
        '{8'h42, 1'b0, 0, NO_REC, NO_REC},
        '{8'h60, 1'b0, 0, NO_REC, NO_REC},
        '{8'h82, 1'b1, 1, SUM_NONE, NO_REC},
        // signature at offset 0, tail closing on the final byte: image, then summary
        '{8'h89, 1'b0, 0, NO_REC, NO_REC},
        '{8'h50, 1'b0, 0, NO_REC, NO_REC},
        '{8'h4E, 1'b0, 0, NO_REC, NO_REC},
        '{8'h47, 1'b0, 0, NO_REC, NO_REC},
        '{8'h0D, 1'b0, 0, NO_REC, NO_REC},
        '{8'h0A, 1'b0, 0, NO_REC, NO_REC},
        '{8'h1A, 1'b0, 0, NO_REC, NO_REC},
        '{8'h0A, 1'b0, 0, NO_REC, NO_REC},
        '{8'h49, 1'b0, 0, NO_REC, NO_REC},
        '{8'h45, 1'b0, 0, NO_REC, NO_REC},
        '{8'h4E, 1'b0, 0, NO_REC, NO_REC},
        '{8'h44, 1'b0, 0, NO_REC, NO_REC},
        '{8'hAE, 1'b0, 0, NO_REC, NO_REC},
        '{8'h42, 1'b0, 0, NO_REC, NO_REC},
        '{8'h60, 1'b0, 0, NO_REC, NO_REC},
        '{8'h82, 1'b1, 2, IMG_FIRST, SUM_ONE},
        // byte extremes in a two-byte stream
        '{8'h00, 1'b0, 0, NO_REC, NO_REC},
        '{8'hFF, 1'b1, 1, SUM_NONE, NO_REC}
    };

    logic i_clk;
    logic i_rst_n;

    png_sc_in_if  in_ch ();
    png_sc_out_if out_ch ();

    png_stream_carver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state: mirrors the carver's tracking registers.
    logic [55:0]        scan_window = '0;
    logic [FIELD_W-1:0] scan_pos    = '0;
    logic               scan_open   = 1'b0;
    logic [FIELD_W-1:0] scan_start  = '0;
    logic [FIELD_W-1:0] scan_count  = '0;
    int unsigned        scan_fill   = 0;

    t_result     owed_results [$];  // results predicted but not yet seen on o_out
    logic [7:0]  stream_bytes [$];  // random stream being assembled
    int          bytes_sent  = 0;
    int          fails       = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_req    = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Carve one byte: advance the predictor state and return the results it yields.
    function automatic int carve_byte(input logic [7:0] b, input logic eos,
                                      output t_result recs [2]);
        logic [63:0]        seen;
        logic [FIELD_W-1:0] stop_off;
        int                 n;
        seen    = {scan_window, b};
        n       = 0;
        recs[0] = NO_REC;
        recs[1] = NO_REC;
        if (scan_fill >= 7) begin
            if (!scan_open) begin
                if (seen == SIG_PATTERN) begin
                    scan_open  = 1'b1;
                    scan_start = scan_pos - 7;
                end
            end else if (seen == TAIL_PATTERN) begin
                stop_off = (scan_pos != POS_MAX) ? scan_pos + 1 : POS_MAX;
                if (scan_count != COUNT_MAX)
                    scan_count++;
                recs[n] = '{KIND_IMAGE, scan_count, scan_start, stop_off, !eos};
                n++;
                scan_open = 1'b0;
            end
        end
        scan_window = seen[55:0];
        if (scan_fill < 7)
            scan_fill++;
        if (scan_pos != POS_MAX)
            scan_pos++;
        if (eos) begin
            recs[n] = '{KIND_SUMMARY, scan_count, '0, '0, 1'b1};
            n++;
            // the stream is over: forget everything
            scan_window = '0;
            scan_pos    = '0;
            scan_open   = 1'b0;
            scan_start  = '0;
            scan_count  = '0;
            scan_fill   = 0;
        end
        return n;
    endfunction

    // Offer one byte from the falling edge, hold it until the transaction completes,
    // then log what it should produce. Typed records override the predictor's.
    task automatic offer_byte(input logic [7:0] b, input logic eos, input int typed_recs,
                              input t_result rec_a, input t_result rec_b);
        t_result carved [2];
        int      n;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        in_ch.last_byte = eos;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n = carve_byte(b, eos, carved);
        if (typed_recs != 0) begin
            owed_results.push_back(rec_a);
            if (typed_recs == 2)
                owed_results.push_back(rec_b);
        end else begin
            for (int k = 0; k < n; k++)
                owed_results.push_back(carved[k]);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Append the first n bytes of a pattern, most significant byte first.
    task automatic add_pattern(input logic [63:0] pat, input int n);
        for (int k = 0; k < n; k++)
            stream_bytes.push_back(pat[63-8*k -: 8]);
    endtask

    // Append filler; a quarter of it is borrowed from the patterns to provoke near-misses.
    task automatic add_noise(input int n);
        logic [63:0] pat;
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                pat = $urandom_range(1) ? SIG_PATTERN : TAIL_PATTERN;
                stream_bytes.push_back(pat[8*$urandom_range(7) +: 8]);
            end else begin
                stream_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // Assemble a stream: mostly complete images with random bodies, the rest
    // broken signatures, stray tails, images left open and plain filler.
    task automatic build_stream();
        int segs;
        stream_bytes.delete();
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    add_noise($urandom_range(0, 3));
                    add_pattern(SIG_PATTERN, 8);
                    add_noise($urandom_range(0, 12));
                    // a second signature inside the open image must be ignored
                    if ($urandom_range(3) == 0) begin
                        add_pattern(SIG_PATTERN, 8);
                        add_noise($urandom_range(0, 4));
                    end
                    // a cut-off tail must not close the image
                    if ($urandom_range(3) == 0) begin
                        add_pattern(TAIL_PATTERN, $urandom_range(1, 7));
                        add_noise(1);
                    end
                    add_pattern(TAIL_PATTERN, 8);
                end
                6: begin
                    add_pattern(SIG_PATTERN, $urandom_range(1, 7));
                    add_noise($urandom_range(1, 4));
                end
                7: add_pattern(TAIL_PATTERN, 8);
                8: begin
                    add_pattern(SIG_PATTERN, 8);
                    add_noise($urandom_range(0, 6));
                end
                default: add_noise($urandom_range(1, 10));
            endcase
        end
        add_noise($urandom_range(0, 2));
    endtask

    task automatic offer_stream();
        foreach (stream_bytes[i])
            offer_byte(stream_bytes[i], i == stream_bytes.size() - 1, 0, NO_REC, NO_REC);
    endtask

    // Receiver: drop ready at random, or for a long stretch when a hold-off is asked.
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check every result transaction against the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (owed_results.size() == 0) begin
                $error("result with nothing outstanding: kind %0d image_count %0d",
                       out_ch.kind, out_ch.image_count);
                fails++;
            end else begin
                want = owed_results.pop_front();
                if (out_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
                    fails++;
                end
                if (out_ch.image_count !== want.image_count) begin
                    $error("image_count: expected %0d, got %0d",
                           want.image_count, out_ch.image_count);
                    fails++;
                end
                if (out_ch.start_offset !== want.start_offset) begin
                    $error("start_offset: expected %0d, got %0d",
                           want.start_offset, out_ch.start_offset);
                    fails++;
                end
                if (out_ch.end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, got %0d",
                           want.end_offset, out_ch.end_offset);
                    fails++;
                end
                if (out_ch.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, out_ch.last_result);
                    fails++;
                end
            end
        end
    end

    // Watchdog: end the run once no transaction has moved for too long.
    initial begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int target;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows, no idling on either side.
        foreach (directed_rows[i])
            offer_byte(directed_rows[i].octet, directed_rows[i].eos,
                       directed_rows[i].typed_recs, directed_rows[i].rec_a,
                       directed_rows[i].rec_b);

        // Random streams over three idling profiles.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 25;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Hold the receiver off while back-to-back images pour in, so
                    // that the result queue fills and input ready drops.
                    hold_req = 1'b1;
                    stream_bytes.delete();
                    repeat (6) begin
                        add_pattern(SIG_PATTERN, 8);
                        add_pattern(TAIL_PATTERN, 8);
                    end
                    add_noise(1);
                    offer_stream();
                end
            endcase
            target = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target) begin
                build_stream();
                offer_stream();
            end
        end
        in_ch.valid = 1'b0;

        // Drain every outstanding result, then allow for a stray late one.
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/png_sc_pkg.sv
hdl/png_sc_if.sv
hdl/png_sc_scan.sv
hdl/png_sc_resq.sv
hdl/png_stream_carver.sv
dv/png_stream_carver_tb.sv
